// ===== rtl/core/embedding_lookup_grad_accumulate_core_assert.svh =====
// Assertion macros shared by the embedding engine RTL.
// Each expands to a labeled concurrent assertion clocked on clk, disabled in reset.
`ifndef EMBEDDING_LOOKUP_GRAD_ACCUMULATE_CORE_ASSERT_SVH
`define EMBEDDING_LOOKUP_GRAD_ACCUMULATE_CORE_ASSERT_SVH

// same-cycle implication
`define ELGA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elga assertion failed");

// next-cycle implication
`define ELGA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elga assertion failed");

`endif

// ===== rtl/core/elga_pkg.sv =====
// Package for the embedding lookup and gradient accumulate engine.
// Holds sizes, command and state codes, controller/datapath structs and helpers.
package elga_pkg;

    localparam int VOCAB      = 1024;
    localparam int DIM        = 16;
    localparam int DEPTH      = VOCAB * DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int TOK_W      = $clog2(VOCAB);
    localparam int COL_W      = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int Q_W        = 32;
    localparam int ELEM_W     = 4;
    localparam int COLUMN_W   = 4;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE,
        CMD_LOOKUP,
        CMD_ACCUM,
        CMD_READ
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCUM,
        ST_READ,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic take;        // latch the accepted beat
        logic wr_weight;   // store weight element from the input beat
        logic grad_rd_in;  // read gradient at the input beat's address
        logic accum_wr;    // write saturated sum back
        logic clr_wr;      // clearing pass: zero one gradient entry
        logic lk_start;    // start a row lookup at column 0
        logic lk_next;     // emit current column, fetch the next
        logic rd_out;      // emit the gradient read result
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic col_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [TOK_W-1:0] clamp_token(input logic signed [Q_W-1:0] tok);
        logic [TOK_W-1:0] r;
        if (tok[Q_W-1])
            r = '0;
        else if (tok >= VOCAB)
            r = TOK_W'(VOCAB - 1);
        else
            r = tok[TOK_W-1:0];
        return r;
    endfunction

    function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [Q_W-1:0] s;
        s = a + b;
        if ((a[Q_W-1] == b[Q_W-1]) && (s[Q_W-1] != a[Q_W-1]))
            s = a[Q_W-1] ? Q_MIN : Q_MAX;
        return s;
    endfunction

endpackage

// ===== rtl/core/embedding_lookup_grad_accumulate_core.sv =====
// Embedding engine: a write stores its element on accept; an accumulate reads the gradient
// on accept and writes the saturated sum back in ST_ACCUM; a read emits its beat from ST_READ
// once the output is free; a lookup fetches column 0 on accept, then emits one column per
// cycle while m_tready does not stall it. No beat is accepted outside ST_IDLE.
// After reset the gradient table is zeroed, one entry a cycle, all VOCAB*DIM = 16384
// entries with s_tready low; weight contents stay undefined until written.
module embedding_lookup_grad_accumulate_core
    import elga_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // token[31:0], element[35:32], value[67:36]
    input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // data[31:0], column[35:32]
    output logic                  m_tlast
);

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    logic signed [Q_W-1:0] out_data;
    logic [COLUMN_W-1:0]   out_column;

    elga_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .sts        (sts),
        .cmd        (cmd)
    );

    elga_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_token   (s_tdata[31:0]),
        .in_element (s_tdata[35:32]),
        .in_value   (s_tdata[67:36]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_column (out_column),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - Q_W - COLUMN_W){1'b0}}, out_column, out_data};

endmodule

// ===== rtl/core/elga_dp.sv =====
// Datapath of the embedding engine: weight and gradient memories, token clamp,
// saturating accumulate, lookup column counter, clearing counter and output register.
// Depends on elga_pkg.
module elga_dp
    import elga_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_sts_t                     sts,
    input  logic signed [Q_W-1:0]       in_token,
    input  logic [ELEM_W-1:0]           in_element,
    input  logic signed [Q_W-1:0]       in_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [Q_W-1:0]       out_data,
    output logic [COLUMN_W-1:0]         out_column,
    output logic                        out_last
);

    logic [Q_W-1:0]      weight_mem [DEPTH];
    logic [Q_W-1:0]      grad_mem   [DEPTH];

    logic [Q_W-1:0]      w_rdata_reg;
    logic [Q_W-1:0]      g_rdata_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [Q_W-1:0]      val_reg;
    logic [ELEM_W-1:0]   elem_reg;
    logic                in_row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [Q_W-1:0]      out_data_reg;
    logic [COLUMN_W-1:0] out_col_reg;
    logic                out_last_reg;

    logic [TOK_W-1:0]    tok_in;
    logic                in_row_in;
    logic [ADDR_W-1:0]   row_in;
    logic [ADDR_W-1:0]   addr_in;
    logic [COL_W-1:0]    col_plus;
    logic                col_last;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_rd_en;
    logic                w_wr_en;
    logic                g_wr_en;
    logic [ADDR_W-1:0]   g_wr_addr;
    logic [Q_W-1:0]      g_wr_data;
    logic                out_load;

    always_comb
    begin
        tok_in    = clamp_token(in_token);
        in_row_in = int'(in_element) < DIM;
        row_in    = ADDR_W'(tok_in) * ADDR_W'(DIM);
        addr_in   = row_in + ADDR_W'(in_element);
        col_plus  = col_reg + COL_W'(1);
        col_last  = (col_reg == COL_W'(DIM - 1));

        // next column's read goes out while the current one is emitted
        w_rd_en   = cmd.lk_start | (cmd.lk_next & !col_last);
        w_rd_addr = cmd.lk_start ? row_in : base_reg + ADDR_W'(col_plus);
        w_wr_en   = cmd.wr_weight & in_row_in;

        g_wr_en   = cmd.clr_wr | (cmd.accum_wr & in_row_reg);
        g_wr_addr = cmd.clr_wr ? clr_addr_reg : addr_reg;
        g_wr_data = cmd.clr_wr ? '0 : sat_add(g_rdata_reg, val_reg);

        out_load       = cmd.lk_next | cmd.rd_out;
        out_valid_next = out_load | (out_valid_reg & !out_ready);

        if (cmd.lk_start)
            col_next = '0;
        else if (cmd.lk_next)
            col_next = col_plus;
        else
            col_next = col_reg;

        clr_addr_next = cmd.clr_wr ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;

        sts.clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
        sts.col_last = col_last;
        sts.out_free = !out_valid_reg | out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (w_wr_en)
            weight_mem[addr_in] <= in_value;
        if (w_rd_en)
            w_rdata_reg <= weight_mem[w_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (g_wr_en)
            grad_mem[g_wr_addr] <= g_wr_data;
        if (cmd.grad_rd_in)
            g_rdata_reg <= grad_mem[addr_in];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            addr_reg   <= addr_in;
            base_reg   <= row_in;
            val_reg    <= in_value;
            elem_reg   <= in_element;
            in_row_reg <= in_row_in;
        end
        if (cmd.lk_next)
        begin
            out_data_reg <= w_rdata_reg;
            out_col_reg  <= COLUMN_W'(col_reg);
            out_last_reg <= col_last;
        end
        else if (cmd.rd_out)
        begin
            // element beyond the row reads as zero
            out_data_reg <= in_row_reg ? g_rdata_reg : '0;
            out_col_reg  <= elem_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_column = out_col_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/core/elga_ctrl.sv =====
// Controller of the embedding engine: clearing pass, command decode and sequencing.
// Depends on elga_pkg and the assertion macro header.
`include "embedding_lookup_grad_accumulate_core_assert.svh"

module elga_ctrl
    import elga_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] in_command,
    input  dp_sts_t          sts,
    output dp_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (cmd_t'(in_command))
                        CMD_WRITE:  cmd.wr_weight = 1'b1;
                        CMD_LOOKUP:
                        begin
                            cmd.lk_start = 1'b1;
                            state_next   = ST_LOOKUP;
                        end
                        CMD_ACCUM:
                        begin
                            cmd.grad_rd_in = 1'b1;
                            state_next     = ST_ACCUM;
                        end
                        CMD_READ:
                        begin
                            cmd.grad_rd_in = 1'b1;
                            state_next     = ST_READ;
                        end
                        default:    cmd.take = 1'b1;
                    endcase
                end
            end
            ST_ACCUM:
            begin
                cmd.accum_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_READ:
            begin
                // hold the read data until the output register frees up
                if (sts.out_free)
                begin
                    cmd.rd_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (sts.out_free)
                begin
                    cmd.lk_next = 1'b1;
                    if (sts.col_last)
                        state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    `ELGA_ASSERT_NXT(a_clear_ends_idle, state_reg == ST_CLEAR && sts.clr_last, state_reg == ST_IDLE)
    `ELGA_ASSERT_IMP(a_emit_needs_room, cmd.lk_next || cmd.rd_out, sts.out_free)
    `ELGA_ASSERT_IMP(a_accum_after_read, cmd.accum_wr, $past(cmd.grad_rd_in))
    `ELGA_ASSERT_IMP(a_no_accept_in_clear, state_reg == ST_CLEAR, !cmd.take && !cmd.clr_wr == 1'b0)

endmodule
